/* rtl/mqs_pkg.sv */
// Shared constants and control types for the matrix quadrant swap block.
`timescale 1ns / 1ps

package mqs_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int SIZE_W   = 7;
  localparam int CNT_W    = ADDR_W + 1;
  localparam int TOT_W    = 2 * SIZE_W;
  localparam int ELEM_W   = 64;
  localparam int DATA_W   = 2 * ELEM_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;        // store the incoming element
    logic fetch_start;  // latch source position, advance read position
    logic reject;       // load a not-ready result
    logic rd_en;        // read the frame store
    logic load_out;     // move read data into the output register
  } mqs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;         // every element of the frame has been written
  } mqs_stat_t;

  // Clamp a raw size register into 1..max
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > max) r = max;
    return r;
  endfunction

endpackage

/* rtl/mqs_ctrl.sv */
// Controller state machine: accepts transactions and sequences fetch reads.
`timescale 1ns / 1ps

module mqs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  mqs_pkg::mqs_stat_t stat,
  output mqs_pkg::mqs_cmd_t  cmd
);
  import mqs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       slot_free;
  logic       accept;

  assign slot_free = !out_tvalid || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == CMD_WRITE) begin
            cmd.wr_en = 1'b1;
          end else if (stat.full) begin
            cmd.fetch_start = 1'b1;
            state_nxt       = ST_READ;
          end else begin
            cmd.reject = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // hold read data until the output register is free
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  a_read_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch_start |=> cmd.rd_en) else $error("read did not follow fetch start");
  a_load_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> state_r == ST_LOAD) else $error("no load stage after read");
  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !(cmd.wr_en || cmd.reject || cmd.fetch_start))
    else $error("transaction taken while a fetch is in flight");

endmodule

/* rtl/mqs_datapath.sv */
// Datapath: size registers, frame store, position counters and output register.
`timescale 1ns / 1ps

module mqs_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mqs_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mqs_pkg::SIZE_W-1:0]     cfg_wdata,
  input  logic [mqs_pkg::DATA_W-1:0]     in_tdata,
  input  mqs_pkg::mqs_cmd_t              cmd,
  output mqs_pkg::mqs_stat_t             stat,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mqs_pkg::DATA_W-1:0]     out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser
);
  import mqs_pkg::*;

  localparam logic [SIZE_W-1:0] ROWS_MAX = SIZE_W'(MAX_ROWS);
  localparam logic [SIZE_W-1:0] COLS_MAX = SIZE_W'(MAX_COLS);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [SIZE_W-1:0] rows_r, cols_r;
  logic [CNT_W-1:0]  write_count_r;
  logic [ROW_W-1:0]  read_row_r, src_row_r;
  logic [COL_W-1:0]  read_col_r, src_col_r;
  logic              last_r;
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_last_r, out_user_r, out_valid_r;

  logic [TOT_W-1:0]  total;
  logic [SIZE_W-1:0] row_sum, col_sum;
  logic [ROW_W-1:0]  src_row;
  logic [COL_W-1:0]  src_col;
  logic              row_end, col_end, last;
  logic [CNT_W-1:0]  addr_full;
  logic [ADDR_W-1:0] rd_addr;

  assign total     = TOT_W'(rows_r) * TOT_W'(cols_r);
  assign stat.full = (TOT_W'(write_count_r) == total);

  // source position: (pos + size/2) mod size by one compare-subtract
  assign row_sum = SIZE_W'(read_row_r) + (rows_r >> 1);
  assign col_sum = SIZE_W'(read_col_r) + (cols_r >> 1);
  assign src_row = (row_sum >= rows_r) ? ROW_W'(row_sum - rows_r) : ROW_W'(row_sum);
  assign src_col = (col_sum >= cols_r) ? COL_W'(col_sum - cols_r) : COL_W'(col_sum);

  assign row_end = (SIZE_W'(read_row_r) + SIZE_W'(1)) == rows_r;
  assign col_end = (SIZE_W'(read_col_r) + SIZE_W'(1)) == cols_r;
  assign last    = row_end && col_end;

  assign addr_full = CNT_W'(src_row_r) * CNT_W'(cols_r) + CNT_W'(src_col_r);
  assign rd_addr   = addr_full[ADDR_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r        <= SIZE_W'(1);
      cols_r        <= SIZE_W'(1);
      write_count_r <= '0;
      read_row_r    <= '0;
      read_col_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        // any size change empties the frame
        if (cfg_addr == REG_NUM_ROWS) rows_r <= clamp_size(cfg_wdata, ROWS_MAX);
        if (cfg_addr == REG_NUM_COLS) cols_r <= clamp_size(cfg_wdata, COLS_MAX);
        write_count_r <= '0;
        read_row_r    <= '0;
        read_col_r    <= '0;
      end else if (cmd.wr_en && !stat.full) begin
        write_count_r <= write_count_r + CNT_W'(1);
      end else if (cmd.fetch_start) begin
        if (last) begin
          write_count_r <= '0;
          read_row_r    <= '0;
          read_col_r    <= '0;
        end else if (col_end) begin
          read_col_r <= '0;
          read_row_r <= read_row_r + ROW_W'(1);
        end else begin
          read_col_r <= read_col_r + COL_W'(1);
        end
      end
      if (cmd.load_out || cmd.reject) out_valid_r <= 1'b1;
      else if (out_tready)            out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.fetch_start) begin
      src_row_r <= src_row;
      src_col_r <= src_col;
      last_r    <= last;
    end
    if (cmd.load_out) begin
      out_data_r <= rdata_r;
      out_last_r <= last_r;
      out_user_r <= STATUS_OK;
    end else if (cmd.reject) begin
      out_data_r <= '0;
      out_last_r <= 1'b0;
      out_user_r <= STATUS_NOT_READY;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (cmd.wr_en && !stat.full) mem[write_count_r[ADDR_W-1:0]] <= in_tdata;
    if (cmd.rd_en)               rdata_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    TOT_W'(write_count_r) <= total) else $error("write count beyond frame size");
  a_fetch_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch_start |-> stat.full) else $error("fetch started on partial frame");
  a_not_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r == STATUS_NOT_READY) |-> (out_data_r == '0 && !out_last_r))
    else $error("not-ready result carries data");

endmodule

/* rtl/matrix_quadrant_swap.sv */
// Top level of the matrix quadrant swap (two-dimensional fftshift) block.
`timescale 1ns / 1ps

// Loads a complex matrix of num_rows by num_cols elements (each 1..64) in
// row-major order into a 4096-entry frame store, then returns it quadrant-
// swapped: fetch n gives input((r + R/2) mod R, (c + C/2) mod C) for output
// position (r,c), so odd sizes follow the inverse-shift direction. Each input
// transaction carries a command on in_tuser: write the next element, or fetch
// the next swapped element. A write gives no result; writes beyond a full frame
// are dropped. A fetch on a partially loaded frame gives one result with status
// 1 and zero data. A fetch on a full frame gives the element with status 0 and
// holds off further input while it forms the source position, reads the frame
// store (a registered read) and loads the output register once it is free. The
// final fetch carries out_tlast and empties the frame. A write to either size
// register empties the frame too; sizes of 0 act as 1 and sizes above 64 act as
// 64. The store needs no clearing after reset: only elements written in the
// current frame are read. Input is taken whenever no fetch is in progress and
// the output register is empty or being drained.

module matrix_quadrant_swap (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [mqs_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mqs_pkg::SIZE_W-1:0]     cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mqs_pkg::DATA_W-1:0]     in_tdata,   // real_bits[63:0], imag_bits[127:64]
  input  logic                           in_tuser,   // cmd
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mqs_pkg::DATA_W-1:0]     out_tdata,  // real_out[63:0], imag_out[127:64]
  output logic                           out_tlast,  // last_out
  output logic                           out_tuser   // status
);
  import mqs_pkg::*;

  mqs_cmd_t  cmd;
  mqs_stat_t stat;

  // sequence transactions and fetch reads
  mqs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // hold sizes, the frame store and the output register
  mqs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_en, cmd.fetch_start, cmd.reject, cmd.rd_en, cmd.load_out}))
    else $error("controller issued more than one command");
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && !out_tvalid) |=> !out_tvalid)
    else $error("write transaction produced a result");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out || cmd.reject) |=> out_tvalid)
    else $error("result lost on load");

endmodule
